FILE: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, codes and character recognisers shared by the token splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int POS_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        S_NORMAL,
        S_HEX0,
        S_HEX1,
        S_BAD
    } str_state_t;

    typedef enum logic [3:0] {
        N_START,
        N_SIGN,
        N_INTD,
        N_DOT0,
        N_DOTD,
        N_EXP0,
        N_EXPS,
        N_EXPD,
        N_BAD
    } num_state_t;

    typedef enum logic [2:0] {
        A_START,
        A_ID,
        A_PATH,
        A_DOTS,
        A_BAD
    } name_state_t;

    typedef enum logic [2:0] {
        CLS_STRING,
        CLS_INTEGER,
        CLS_FLOAT,
        CLS_IDENT,
        CLS_PATH,
        CLS_UNKNOWN
    } tok_class_t;

    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        tok_class_t          cls;
    } tok_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_escape_ok(input logic [7:0] c);
        // \\ \a \b \f \n \r \t \v \"
        return c inside {CH_BSLASH, 8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
                         CH_QUOTE};
    endfunction

    function automatic num_state_t number_next(input num_state_t s, input logic [7:0] c);
        logic d;
        d = is_digit(c);
        case (s)
            N_START: return is_sign(c) ? N_SIGN : d ? N_INTD : (c == CH_DOT) ? N_DOT0 : N_BAD;
            N_SIGN:  return d ? N_INTD : (c == CH_DOT) ? N_DOT0 : N_BAD;
            N_INTD:  return d ? N_INTD : (c == CH_DOT) ? N_DOTD : (c == CH_E) ? N_EXP0 : N_BAD;
            N_DOT0:  return d ? N_DOTD : (c == CH_DOT) ? N_DOT0 : N_BAD;
            N_DOTD:  return (d || c == CH_DOT) ? N_DOTD : (c == CH_E) ? N_EXP0 : N_BAD;
            N_EXP0:  return is_sign(c) ? N_EXPS : d ? N_EXPD : N_BAD;
            N_EXPS,
            N_EXPD:  return d ? N_EXPD : N_BAD;
            default: return N_BAD;
        endcase
    endfunction

    function automatic name_state_t name_next(input name_state_t s, input logic [7:0] c);
        logic wrd;
        logic pathc;
        wrd = is_alpha(c) || is_digit(c) || (c == CH_USCORE);
        pathc = wrd || (c == CH_SLASH) || (c == CH_MINUS);
        case (s)
            A_START: begin
                if (is_alpha(c) || c == CH_USCORE) return A_ID;
                return pathc ? A_PATH : (c == CH_DOT) ? A_DOTS : A_BAD;
            end
            A_ID:    return wrd ? A_ID : pathc ? A_PATH : (c == CH_DOT) ? A_DOTS : A_BAD;
            A_PATH:  return pathc ? A_PATH : (c == CH_DOT) ? A_DOTS : A_BAD;
            A_DOTS:  return (c == CH_DOT) ? A_DOTS : (c == CH_SLASH) ? A_PATH : A_BAD;
            default: return A_BAD;
        endcase
    endfunction

    function automatic tok_class_t plain_class(input num_state_t n, input name_state_t a);
        if (n == N_SIGN || n == N_INTD) return CLS_INTEGER;
        if (n == N_DOTD || n == N_EXPD) return CLS_FLOAT;
        if (a == A_ID) return CLS_IDENT;
        if (a == A_PATH || a == A_DOTS) return CLS_PATH;
        return CLS_UNKNOWN;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/token_splitter_classifier.sv
// ----------------------------------------------------------------------------
// token_splitter_classifier
// Splits a byte stream into whitespace-separated tokens and classifies each.
// ----------------------------------------------------------------------------
// Input stream: one text byte per word on s_tdata, s_tlast on the final byte
// of a text. Output stream: one word per token with its start offset, length
// and class (string, integer, float, identifier, path, unknown).
// Throughput is one byte per cycle unless a held result stalls the output,
// set by the recogniser update in the tracker. A result passes two registers:
// the input register, then the tracker and the result register. A token
// ends on the whitespace byte after it, on its closing quote, or on s_tlast.
// After s_tlast all token state and the offset counter return to zero.
// When m_tready is low with a result held, the input register keeps one byte
// and s_tready drops; no word is lost or repeated.
// Reset (aresetn low, synchronous) empties both registers and clears state.
// ----------------------------------------------------------------------------
`default_nettype none

module token_splitter_classifier (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [15:0] token_start, [31:16] token_length,
                                        // [34:32] token_class, [39:35] zero
);
    import tsc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        advance;
    tok_result_t res;

    assign advance = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    tsc_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (in_valid_reg && advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .result      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_data_reg <= {5'b0, res.cls, res.length, res.start};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/tsc_tracker.sv
// ----------------------------------------------------------------------------
// tsc_tracker
// Token state and recognisers; one byte per step, one token result at most.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_tracker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 end_of_text,
    output tsc_pkg::tok_result_t      result
);
    import tsc_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic                in_tok_reg, in_tok_next;
    logic                quoted_reg, quoted_next;
    logic                esc_reg, esc_next;
    str_state_t          str_reg, str_next;
    num_state_t          num_reg, num_next;
    name_state_t         name_reg, name_next_s;

    logic                emit;
    logic                end_incl;
    tok_class_t          emit_cls;
    logic [POS_BITS-1:0] tok_start;
    logic [POS_BITS:0]   end_off;
    logic [POS_BITS:0]   len_raw;
    logic [POS_BITS-1:0] len_sat;

    always_comb begin
        pos_next = pos_reg;
        tstart_next = tstart_reg;
        in_tok_next = in_tok_reg;
        quoted_next = quoted_reg;
        esc_next = esc_reg;
        str_next = str_reg;
        num_next = num_reg;
        name_next_s = name_reg;
        emit = 1'b0;
        end_incl = 1'b1;
        emit_cls = CLS_UNKNOWN;

        if (!in_tok_reg) begin
            if (!is_space(text_byte)) begin
                tstart_next = pos_reg;
                in_tok_next = 1'b1;
                if (text_byte == CH_QUOTE) begin
                    quoted_next = 1'b1;
                    esc_next = 1'b0;
                    str_next = S_NORMAL;
                    emit = end_of_text;
                    emit_cls = CLS_STRING;
                end else begin
                    quoted_next = 1'b0;
                    num_next = number_next(N_START, text_byte);
                    name_next_s = name_next(A_START, text_byte);
                    emit = end_of_text;
                    emit_cls = plain_class(num_next, name_next_s);
                end
            end
        end else if (quoted_reg) begin
            if (esc_reg) begin
                esc_next = 1'b0;
                if (str_reg != S_BAD) begin
                    if (text_byte == CH_X) begin
                        str_next = S_HEX0;
                    end else if (is_escape_ok(text_byte)) begin
                        str_next = S_NORMAL;
                    end else begin
                        str_next = S_BAD;
                    end
                end
                emit = end_of_text;
                emit_cls = CLS_UNKNOWN;
            end else begin
                if (str_reg == S_HEX0) begin
                    str_next = is_hex(text_byte) ? S_HEX1 : S_BAD;
                end else if (str_reg == S_HEX1) begin
                    str_next = is_hex(text_byte) ? S_NORMAL : S_BAD;
                end
                if (text_byte == CH_QUOTE) begin
                    emit = 1'b1;
                    emit_cls = (str_next == S_NORMAL) ? CLS_STRING : CLS_UNKNOWN;
                end else begin
                    if (text_byte == CH_BSLASH) esc_next = 1'b1;
                    emit = end_of_text;
                    emit_cls = CLS_UNKNOWN;
                end
            end
        end else begin
            if (is_space(text_byte)) begin
                emit = 1'b1;
                end_incl = 1'b0;
                emit_cls = plain_class(num_reg, name_reg);
            end else begin
                num_next = number_next(num_reg, text_byte);
                name_next_s = name_next(name_reg, text_byte);
                emit = end_of_text;
                emit_cls = plain_class(num_next, name_next_s);
            end
        end

        // start of the token being closed, taken before the end-of-text clear
        tok_start = tstart_next;

        if (emit) begin
            in_tok_next = 1'b0;
            quoted_next = 1'b0;
            esc_next = 1'b0;
        end

        if (end_of_text) begin
            pos_next = '0;
            tstart_next = '0;
            in_tok_next = 1'b0;
            quoted_next = 1'b0;
            esc_next = 1'b0;
            str_next = S_NORMAL;
            num_next = N_START;
            name_next_s = A_START;
        end else if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // length from saturated offsets, clamped to 1..POS_MAX
    always_comb begin
        end_off = {1'b0, pos_reg} + {{POS_BITS{1'b0}}, end_incl};
        len_raw = (end_off > {1'b0, tok_start}) ? (end_off - {1'b0, tok_start}) : '0;
        if (len_raw == '0) begin
            len_sat = {{(POS_BITS-1){1'b0}}, 1'b1};
        end else if (len_raw[POS_BITS]) begin
            len_sat = POS_MAX;
        end else begin
            len_sat = len_raw[POS_BITS-1:0];
        end
    end

    always_comb begin
        result.valid = step && emit;
        result.start = tok_start[OUT_BITS-1:0];
        result.length = len_sat[OUT_BITS-1:0];
        result.cls = emit_cls;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            tstart_reg <= '0;
            in_tok_reg <= 1'b0;
            quoted_reg <= 1'b0;
            esc_reg <= 1'b0;
            str_reg <= S_NORMAL;
            num_reg <= N_START;
            name_reg <= A_START;
        end else if (step) begin
            pos_reg <= pos_next;
            tstart_reg <= tstart_next;
            in_tok_reg <= in_tok_next;
            quoted_reg <= quoted_next;
            esc_reg <= esc_next;
            str_reg <= str_next;
            num_reg <= num_next;
            name_reg <= name_next_s;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks for the token splitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata
);
    import tsc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:16] != 16'd0)
        else $error("token length of zero");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:32] <= 3'(CLS_UNKNOWN) && m_tdata[39:35] == 5'd0)
        else $error("bad class or padding");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an input word two cycles before");

endmodule

bind token_splitter_classifier tsc_checker u_tsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
